>>> rtl/c3p_pkg.sv
package c3p_pkg;

  // Default coordinate width: signed Q12.4 pixels.
  localparam int COORD_WIDTH_DEFAULT = 16;

endpackage

>>> rtl/c3p_div.sv
module c3p_div
  import c3p_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic signed [3*COORD_WIDTH+4:0] num,
  input  logic signed [2*COORD_WIDTH+3:0] den,
  output logic signed [COORD_WIDTH-1:0] coord,
  output logic                          sat
);

  localparam int W  = COORD_WIDTH;
  localparam int NW = 3 * W + 5;
  localparam int DW = 2 * W + 4;

  // magnitudes and quotient sign
  logic          neg_a;
  logic [NW-1:0] an_a;
  logic [DW-1:0] ad_a;

  always_ff @(posedge clk) begin
    neg_a <= num[NW-1] ^ den[DW-1];
    an_a  <= num[NW-1] ? NW'(-num) : NW'(num);
    ad_a  <= den[DW-1] ? DW'(-den) : DW'(den);
  end

  // restoring steps, one quotient bit each
  logic [NW-1:0] rem [0:W-1];
  logic [DW-1:0] dd  [0:W-1];
  logic [W-1:0]  q   [0:W];
  logic          neg [0:W];
  logic          ovf [0:W];

  always_ff @(posedge clk) begin
    rem[0] <= an_a;
    dd[0]  <= ad_a;
    q[0]   <= '0;
    neg[0] <= neg_a;
    // quotient magnitude of 2^W or more clamps anyway
    ovf[0] <= an_a >= (NW'(ad_a) << W);
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    localparam int B = W - 1 - k;
    logic [NW-1:0] sh;
    logic          ge;

    always_comb begin
      sh = NW'(dd[k]) << B;
      ge = rem[k] >= sh;
    end

    always_ff @(posedge clk) begin
      q[k+1]   <= {q[k][W-2:0], ge};
      neg[k+1] <= neg[k];
      ovf[k+1] <= ovf[k];
    end

    if (k < W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem[k+1] <= ge ? rem[k] - sh : rem[k];
        dd[k+1]  <= dd[k];
      end
    end
  end

  // apply sign and clamp to the signed range
  logic [W-1:0] mag;
  logic         big_pos;
  logic         big_neg;

  always_comb begin
    mag     = q[W];
    big_pos = mag[W-1];
    big_neg = mag[W-1] && (|mag[W-2:0]);
  end

  always_ff @(posedge clk) begin
    if (ovf[W] || (neg[W] ? big_neg : big_pos)) begin
      sat   <= 1'b1;
      coord <= neg[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      sat   <= 1'b0;
      coord <= neg[W] ? W'(-mag) : mag;
    end
  end

endmodule

>>> rtl/c3p_sqrt.sv
module c3p_sqrt
  import c3p_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic [2*COORD_WIDTH+1:0] rsq,
  output logic [COORD_WIDTH:0]     root
);

  localparam int W  = COORD_WIDTH;
  localparam int RW = 2 * W + 2;

  logic [RW-1:0] rem [0:W];
  logic [W:0]    rt  [0:W+1];

  assign rem[0] = rsq;
  assign rt[0]  = '0;

  // one root bit per stage, from the top bit down
  for (genvar k = 0; k <= W; k++) begin : g_step
    localparam int B = W - k;
    logic [RW-1:0] cand;
    logic          ge;

    always_comb begin
      cand = (RW'(rt[k]) << (B + 1)) | (RW'(1) << (2 * B));
      ge   = rem[k] >= cand;
    end

    always_ff @(posedge clk) begin
      rt[k+1] <= ge ? (rt[k] | ((W+1)'(1) << B)) : rt[k];
    end

    if (k < W) begin : g_carry
      always_ff @(posedge clk) begin
        rem[k+1] <= ge ? rem[k] - cand : rem[k];
      end
    end
  end

  assign root = rt[W+1];

endmodule

>>> rtl/circle_from_three_points.sv
// Channel   Handshake            Ports
// request   start (busy low)     first_x, first_y, second_x, second_y, third_x, third_y
// result    done, one cycle      center_x, center_y, radius, degenerate, saturated
//
// Path: a request passes through the input stages, the two quotient pipelines (one bit per
// stage), the radius stages, the root pipeline (one bit per stage) and the output register
// that drives done.
// Throughput: one request every cycle; busy stays low.
// Reset: rst clears every valid bit; payload registers are not reset.
// Stalls: none; the receiver takes each result in the cycle done is high.
module circle_from_three_points
  import c3p_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] third_x,
  input  logic signed [COORD_WIDTH-1:0] third_y,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] center_x,
  output logic signed [COORD_WIDTH-1:0] center_y,
  output logic [COORD_WIDTH-1:0]        radius,
  output logic                          degenerate,
  output logic                          saturated
);

  localparam int W   = COORD_WIDTH;
  localparam int DL  = W + 3;      // divider depth
  localparam int SL  = W + 1;      // root depth
  localparam int LAT = 2 * W + 14; // request to result

  // The pipeline never holds a request off.
  assign busy = 1'b0;

  logic take;
  assign take = start && !busy;

  // Stage 1: edge vectors from the first point
  logic                  v1;
  logic signed [W-1:0]   x1_1, y1_1;
  logic signed [W:0]     ux_1, uy_1, vx_1, vy_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= take;
    end
    x1_1 <= first_x;
    y1_1 <= first_y;
    ux_1 <= (W+1)'(second_x) - (W+1)'(first_x);
    uy_1 <= (W+1)'(second_y) - (W+1)'(first_y);
    vx_1 <= (W+1)'(third_x) - (W+1)'(first_x);
    vy_1 <= (W+1)'(third_y) - (W+1)'(first_y);
  end

  // Stage 2: squares and cross products
  logic                  v2;
  logic signed [W-1:0]   x1_2, y1_2;
  logic signed [W:0]     ux_2, uy_2, vx_2, vy_2;
  logic signed [2*W+1:0] uxx_2, uyy_2, vxx_2, vyy_2, cra_2, crb_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    x1_2  <= x1_1;
    y1_2  <= y1_1;
    ux_2  <= ux_1;
    uy_2  <= uy_1;
    vx_2  <= vx_1;
    vy_2  <= vy_1;
    uxx_2 <= ux_1 * ux_1;
    uyy_2 <= uy_1 * uy_1;
    vxx_2 <= vx_1 * vx_1;
    vyy_2 <= vy_1 * vy_1;
    cra_2 <= ux_1 * vy_1;
    crb_2 <= uy_1 * vx_1;
  end

  // Stage 3: squared lengths and doubled determinant
  logic                  v3;
  logic signed [W-1:0]   x1_3, y1_3;
  logic signed [W:0]     ux_3, uy_3, vx_3, vy_3;
  logic signed [2*W+2:0] uu_3, vv_3, crs;
  logic signed [2*W+3:0] den_3;

  always_comb begin
    crs = cra_2 - crb_2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    x1_3  <= x1_2;
    y1_3  <= y1_2;
    ux_3  <= ux_2;
    uy_3  <= uy_2;
    vx_3  <= vx_2;
    vy_3  <= vy_2;
    uu_3  <= uxx_2 + uyy_2;
    vv_3  <= vxx_2 + vyy_2;
    den_3 <= {crs, 1'b0};
  end

  // Stage 4: numerator products, first point scaled by the determinant
  logic                  v4;
  logic signed [W-1:0]   x1_4, y1_4;
  logic signed [2*W+3:0] den_4;
  logic signed [3*W+3:0] ma_4, mb_4, mc_4, md_4, xd_4, yd_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    x1_4  <= x1_3;
    y1_4  <= y1_3;
    den_4 <= den_3;
    ma_4  <= vy_3 * uu_3;
    mb_4  <= uy_3 * vv_3;
    mc_4  <= ux_3 * vv_3;
    md_4  <= vx_3 * uu_3;
    xd_4  <= x1_3 * den_3;
    yd_4  <= y1_3 * den_3;
  end

  // Stage 5: offset numerators
  logic                  v5;
  logic signed [W-1:0]   x1_5, y1_5;
  logic signed [2*W+3:0] den_5;
  logic signed [3*W+3:0] xd_5, yd_5;
  logic signed [3*W+4:0] nx_5, ny_5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    x1_5  <= x1_4;
    y1_5  <= y1_4;
    den_5 <= den_4;
    xd_5  <= xd_4;
    yd_5  <= yd_4;
    nx_5  <= ma_4 - mb_4;
    ny_5  <= mc_4 - md_4;
  end

  // Stage 6: absolute numerators; flag a zero determinant
  logic                  v6;
  logic                  dg_6;
  logic signed [W-1:0]   x1_6, y1_6;
  logic signed [2*W+3:0] den_6;
  logic signed [3*W+4:0] numx_6, numy_6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    x1_6   <= x1_5;
    y1_6   <= y1_5;
    den_6  <= den_5;
    dg_6   <= den_5 == '0;
    numx_6 <= xd_5 + nx_5;
    numy_6 <= yd_5 + ny_5;
  end

  // Quotients, truncated toward zero and clamped
  logic signed [W-1:0] cx_d, cy_d;
  logic                sx_d, sy_d;

  c3p_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_x (
    .clk   (clk),
    .num   (numx_6),
    .den   (den_6),
    .coord (cx_d),
    .sat   (sx_d)
  );

  c3p_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_y (
    .clk   (clk),
    .num   (numy_6),
    .den   (den_6),
    .coord (cy_d),
    .sat   (sy_d)
  );

  // Carry valid, flag and first point alongside the dividers
  logic                vd  [1:DL];
  logic                dgd [1:DL];
  logic signed [W-1:0] x1d [1:DL];
  logic signed [W-1:0] y1d [1:DL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= DL; i++) begin
        vd[i] <= 1'b0;
      end
    end else begin
      vd[1] <= v6;
      for (int i = 2; i <= DL; i++) begin
        vd[i] <= vd[i-1];
      end
    end
    dgd[1] <= dg_6;
    x1d[1] <= x1_6;
    y1d[1] <= y1_6;
    for (int i = 2; i <= DL; i++) begin
      dgd[i] <= dgd[i-1];
      x1d[i] <= x1d[i-1];
      y1d[i] <= y1d[i-1];
    end
  end

  // Radius stage a: offset from the clamped center back to the first point
  logic                va, dga, sta;
  logic signed [W-1:0] cxa, cya;
  logic signed [W:0]   dxa, dya;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= vd[DL];
    end
    dga <= dgd[DL];
    sta <= sx_d | sy_d;
    cxa <= cx_d;
    cya <= cy_d;
    dxa <= cx_d - x1d[DL];
    dya <= cy_d - y1d[DL];
  end

  // Radius stage b: squares
  logic                  vb, dgb, stb;
  logic signed [W-1:0]   cxb, cyb;
  logic signed [2*W+1:0] sqx, sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    dgb <= dga;
    stb <= sta;
    cxb <= cxa;
    cyb <= cya;
    sqx <= dxa * dxa;
    sqy <= dya * dya;
  end

  // Radius stage c: squared distance, never negative
  logic                vc, dgc, stc;
  logic signed [W-1:0] cxc, cyc;
  logic [2*W+1:0]      rsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
    dgc <= dgb;
    stc <= stb;
    cxc <= cxb;
    cyc <= cyb;
    rsq <= sqx + sqy;
  end

  logic [W:0] root;

  c3p_sqrt #(.COORD_WIDTH(COORD_WIDTH)) u_sqrt (
    .clk  (clk),
    .rsq  (rsq),
    .root (root)
  );

  // Carry the center and flags alongside the root pipeline
  logic                vs  [1:SL];
  logic                dgs [1:SL];
  logic                sts [1:SL];
  logic signed [W-1:0] cxs [1:SL];
  logic signed [W-1:0] cys [1:SL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= SL; i++) begin
        vs[i] <= 1'b0;
      end
    end else begin
      vs[1] <= vc;
      for (int i = 2; i <= SL; i++) begin
        vs[i] <= vs[i-1];
      end
    end
    dgs[1] <= dgc;
    sts[1] <= stc;
    cxs[1] <= cxc;
    cys[1] <= cyc;
    for (int i = 2; i <= SL; i++) begin
      dgs[i] <= dgs[i-1];
      sts[i] <= sts[i-1];
      cxs[i] <= cxs[i-1];
      cys[i] <= cys[i-1];
    end
  end

  // Output register: clamp the radius; for collinear points zero center, radius and saturated, set degenerate
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vs[SL];
    end
    if (dgs[SL]) begin
      center_x   <= '0;
      center_y   <= '0;
      radius     <= '0;
      degenerate <= 1'b1;
      saturated  <= 1'b0;
    end else begin
      center_x   <= cxs[SL];
      center_y   <= cys[SL];
      radius     <= root[W] ? {W{1'b1}} : root[W-1:0];
      degenerate <= 1'b0;
      saturated  <= sts[SL] | root[W];
    end
  end

  a_latency : assert property (@(posedge clk) disable iff (rst)
    take |-> ##(LAT) done)
    else $error("accepted request did not produce a result on time");

  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> center_x == '0 && center_y == '0 && radius == '0 && !saturated)
    else $error("collinear result carries nonzero fields");

  a_radius_clip : assert property (@(posedge clk) disable iff (rst)
    done && !degenerate && !saturated |-> radius != {W{1'b1}} || $past(root[W], 1) == 1'b0)
    else $error("clipped radius without saturation flag");

endmodule
